// ===== rtl/core/rdqc_pkg.sv =====
`default_nettype none
package rdqc_pkg;

  localparam int MAX_CLUSTERS = 64;
  localparam int ADDR_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);

  // Working width for a field value while it is snapped and clamped.
  localparam int WORK_W = 27;
  localparam int STEP_W = 24;
  localparam int NUM_W = 26;
  localparam int DEN_W = STEP_W + 1;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 48;
  localparam int TDATA_W = 96;

  localparam logic [CFG_ADDR_W-1:0] REG_AZ_LIMITS  = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_EL_LIMITS  = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RNG_LIMITS = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_VEL_LIMIT  = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_ANG_RES    = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_RNG_RES    = 4'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_VEL_RES    = 4'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_MODE       = 4'd7;

  localparam logic [1:0] F_AZ  = 2'd0;
  localparam logic [1:0] F_EL  = 2'd1;
  localparam logic [1:0] F_RNG = 2'd2;
  localparam logic [1:0] F_VEL = 2'd3;

  localparam int MODE_CLUSTER = 4;

  typedef enum logic {DIV_SNAP, DIV_BIN} div_kind_e;
  typedef enum logic {SRC_WORK, SRC_MEM} out_src_e;

  typedef struct packed {
    logic [15:0] cs;
    logic [19:0] vel;
    logic [23:0] rng;
    logic [15:0] el;
    logic [15:0] az;
  } det_t;

  typedef struct packed {
    logic [23:0] rbin;
    logic [15:0] ebin;
    logic [15:0] abin;
  } key_t;

  typedef struct packed {
    key_t key;
    det_t det;
  } entry_t;

  typedef struct packed {
    logic              load;
    logic [1:0]        fsel;
    logic              div_start;
    div_kind_e         div_kind;
    logic              mul;
    logic              snap_apply;
    logic              clamp;
    logic              bin_store;
    logic              rd;
    logic              wr;
    logic [ADDR_W-1:0] addr;
    logic              inc;
    logic              set_ovf;
    logic              clear;
    logic              out_load;
    out_src_e          out_src;
    logic              out_last;
  } cmd_t;

  typedef struct packed {
    logic             div_done;
    logic [4:0]       mode;
    logic [3:0]       step_nz;
    logic             range_ok;
    logic             key_match;
    logic             closer;
    logic [CNT_W-1:0] count;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/radar_detection_quantize_cluster_core.sv =====
`default_nettype none
// Radar detection quantizer and grid clusterer. Each detection item may have its
// fields snapped to a grid and is then clamped to the configured limits; in cluster
// mode a floor-division bin key picks a table entry of up to 64 bins that keeps the
// closest detection, and a flush item (tuser = 1) emits the table in arrival order.
// Items are handled one at a time. All divisions share one radix-2 divider that runs
// 26 iterations and raises done together with the final quotient. A detection is
// accepted, each field is snapped (divide, multiply, add) or skipped, then all are
// clamped and the range is checked; a range outside its limits ends it there. A
// pass-through result is loaded once the output register is free. Clustering divides
// azimuth, elevation and range by their nonzero bin steps, reads and compares the
// stored bins in turn, and inserts a new bin or flags overflow when the table is
// full. A flush emits each stored bin, waiting while the receiver stalls the output.
// The output register lets the next item be accepted while a result waits.
module radar_detection_quantize_cluster_core import rdqc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // azimuth, elevation, range, velocity, cross_section, zero pad
  input  wire logic [TDATA_W-1:0]    s_axis_tdata_i,
  // operation
  input  wire logic                  s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // out_azimuth, out_elevation, out_range, out_velocity, out_cross_section, zero pad
  output logic [TDATA_W-1:0]         m_axis_tdata_o,
  // overflow
  output logic                       m_axis_tuser_o,
  output logic                       m_axis_tlast_o
);

  cmd_t  cmd;
  stat_t stat;
  det_t  out_det;

  assign cfg_ready_o = 1'b1;

  rdqc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_flush_i  (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rdqc_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .in_det_i   (det_t'(s_axis_tdata_i[$bits(det_t)-1:0])),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_det_o  (out_det),
    .out_last_o (m_axis_tlast_o),
    .out_ovf_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{(TDATA_W-$bits(det_t)){1'b0}}, out_det};

endmodule
`default_nettype wire

// ===== rtl/core/rdqc_div.sv =====
`default_nettype none
module rdqc_div import rdqc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   shifted, diff;
  logic             take;

  // Restoring division: one quotient bit per cycle, numerator shifted out of quo_q.
  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign take    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

// ===== rtl/core/rdqc_datapath.sv =====
`default_nettype none
module rdqc_datapath import rdqc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire det_t                  in_det_i,
  input  wire cmd_t                  cmd_i,
  output stat_t                      stat_o,
  output det_t                       out_det_o,
  output logic                       out_last_o,
  output logic                       out_ovf_o
);

  logic [31:0] az_lim_q, el_lim_q, ang_res_q;
  logic [47:0] rng_lim_q;
  logic [18:0] vel_lim_q, vel_res_q;
  logic [23:0] rng_res_q;
  logic [4:0]  mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      az_lim_q  <= 32'h3FFF_C000;
      el_lim_q  <= 32'h3FFF_C000;
      rng_lim_q <= 48'hFFFF_FF00_0000;
      vel_lim_q <= 19'h7FFFF;
      ang_res_q <= '0;
      rng_res_q <= '0;
      vel_res_q <= '0;
      mode_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_AZ_LIMITS:  az_lim_q  <= cfg_data_i[31:0];
        REG_EL_LIMITS:  el_lim_q  <= cfg_data_i[31:0];
        REG_RNG_LIMITS: rng_lim_q <= cfg_data_i[47:0];
        REG_VEL_LIMIT:  vel_lim_q <= cfg_data_i[18:0];
        REG_ANG_RES:    ang_res_q <= cfg_data_i[31:0];
        REG_RNG_RES:    rng_res_q <= cfg_data_i[23:0];
        REG_VEL_RES:    vel_res_q <= cfg_data_i[18:0];
        REG_MODE:       mode_q    <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic signed [WORK_W-1:0] org [4];
  logic signed [WORK_W-1:0] hi [4];
  logic signed [WORK_W-1:0] lo [4];
  logic [STEP_W-1:0]        stp [4];

  always_comb begin
    org[0] = WORK_W'($signed(az_lim_q[15:0]));
    org[1] = WORK_W'($signed(el_lim_q[15:0]));
    org[2] = $signed({{(WORK_W-24){1'b0}}, rng_lim_q[23:0]});
    org[3] = '0;
    hi[0]  = WORK_W'($signed(az_lim_q[31:16]));
    hi[1]  = WORK_W'($signed(el_lim_q[31:16]));
    hi[2]  = $signed({{(WORK_W-24){1'b0}}, rng_lim_q[47:24]});
    hi[3]  = $signed({{(WORK_W-19){1'b0}}, vel_lim_q});
    lo[0]  = org[0];
    lo[1]  = org[1];
    lo[2]  = org[2];
    lo[3]  = -hi[3];
    stp[0] = {{(STEP_W-16){1'b0}}, ang_res_q[15:0]};
    stp[1] = {{(STEP_W-16){1'b0}}, ang_res_q[31:16]};
    stp[2] = rng_res_q;
    stp[3] = {{(STEP_W-19){1'b0}}, vel_res_q};
  end

  logic signed [WORK_W-1:0] work_q [4];
  logic signed [WORK_W-1:0] clamped [4];
  logic [15:0]              cs_q;
  key_t                     key_q;
  logic                     neg_q;
  logic [NUM_W-1:0]         prod_q;

  logic signed [WORK_W-1:0]   diff;
  logic [WORK_W-1:0]          mag;
  logic                       neg;
  logic [STEP_W-1:0]          stp_f;
  logic [WORK_W:0]            snum, bnum;
  logic [NUM_W-1:0]           div_num, quot, bin_val;
  logic [DEN_W-1:0]           div_den;
  logic                       div_done;
  logic [NUM_W+STEP_W-1:0]    prod_full;
  logic signed [WORK_W-1:0]   prod_s;

  assign stp_f = stp[cmd_i.fsel];
  assign diff  = work_q[cmd_i.fsel] - org[cmd_i.fsel];
  assign neg   = diff[WORK_W-1];
  assign mag   = neg ? -diff : diff;
  // Round half away from zero: (2|d| + step) / (2 step).
  assign snum  = {mag, 1'b0} + {{(WORK_W+1-STEP_W){1'b0}}, stp_f};
  // Floor of a negative quotient: -((|d| + step - 1) / step).
  assign bnum  = neg ? ({1'b0, mag} + {{(WORK_W+1-STEP_W){1'b0}}, stp_f} - (WORK_W+1)'(1))
                     : {1'b0, mag};
  assign div_num = (cmd_i.div_kind == DIV_SNAP) ? snum[NUM_W-1:0] : bnum[NUM_W-1:0];
  assign div_den = (cmd_i.div_kind == DIV_SNAP) ? {stp_f, 1'b0} : {1'b0, stp_f};

  rdqc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign prod_full = quot * stp_f;
  assign prod_s    = $signed({1'b0, prod_q});
  assign bin_val   = neg_q ? -quot : quot;

  always_comb begin
    for (int f = 0; f < 4; f++) begin
      clamped[f] = (work_q[f] < lo[f]) ? lo[f] : work_q[f];
      if (clamped[f] > hi[f]) clamped[f] = hi[f];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q[F_AZ]  <= WORK_W'($signed(in_det_i.az));
      work_q[F_EL]  <= WORK_W'($signed(in_det_i.el));
      work_q[F_RNG] <= $signed({{(WORK_W-24){1'b0}}, in_det_i.rng});
      work_q[F_VEL] <= WORK_W'($signed(in_det_i.vel));
      cs_q          <= in_det_i.cs;
      key_q         <= '0;
    end else if (cmd_i.snap_apply) begin
      work_q[cmd_i.fsel] <= neg_q ? org[cmd_i.fsel] - prod_s : org[cmd_i.fsel] + prod_s;
    end else if (cmd_i.clamp) begin
      for (int f = 0; f < 4; f++) work_q[f] <= clamped[f];
    end
    if (cmd_i.div_start) neg_q <= neg;
    if (cmd_i.mul) prod_q <= prod_full[NUM_W-1:0];
    if (cmd_i.bin_store) begin
      case (cmd_i.fsel)
        F_AZ:    key_q.abin <= bin_val[15:0];
        F_EL:    key_q.ebin <= bin_val[15:0];
        default: key_q.rbin <= bin_val[23:0];
      endcase
    end
  end

  det_t   det_now;
  entry_t mem_q [MAX_CLUSTERS];
  entry_t rd_q;

  always_comb begin
    det_now.az  = work_q[F_AZ][15:0];
    det_now.el  = work_q[F_EL][15:0];
    det_now.rng = work_q[F_RNG][23:0];
    det_now.vel = work_q[F_VEL][19:0];
    det_now.cs  = cs_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) mem_q[cmd_i.addr] <= '{key: key_q, det: det_now};
    if (cmd_i.rd) rd_q <= mem_q[cmd_i.addr];
  end

  logic [CNT_W-1:0] count_q;
  logic             ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cmd_i.inc) count_q <= count_q + CNT_W'(1);
      if (cmd_i.set_ovf) ovf_q <= 1'b1;
    end
  end

  det_t out_det_q;
  logic out_last_q, out_ovf_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_det_q  <= (cmd_i.out_src == SRC_MEM) ? rd_q.det : det_now;
      out_last_q <= cmd_i.out_last;
      out_ovf_q  <= (cmd_i.out_src == SRC_MEM) ? ovf_q : 1'b0;
    end
  end

  assign out_det_o  = out_det_q;
  assign out_last_o = out_last_q;
  assign out_ovf_o  = out_ovf_q;

  always_comb begin
    stat_o.div_done  = div_done;
    stat_o.mode      = mode_q;
    for (int f = 0; f < 4; f++) stat_o.step_nz[f] = |stp[f];
    stat_o.range_ok  = work_q[F_RNG] >= org[F_RNG];
    stat_o.key_match = rd_q.key == key_q;
    stat_o.closer    = work_q[F_RNG][23:0] < rd_q.det.rng;
    stat_o.count     = count_q;
  end

endmodule
`default_nettype wire

// ===== rtl/core/rdqc_ctrl.sv =====
`default_nettype none
module rdqc_ctrl import rdqc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  in_flush_i,
  output logic       in_ready_o,
  input  wire logic  out_ready_i,
  output logic       out_valid_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SNAP_CHK, ST_SNAP_DIV, ST_SNAP_MUL, ST_SNAP_ADD, ST_CLAMP, ST_CHECK,
    ST_OUT_PASS, ST_BIN_CHK, ST_BIN_DIV, ST_SRCH_RD, ST_SRCH_CMP, ST_INSERT,
    ST_FL_RD, ST_FL_OUT
  } state_e;

  state_e            state_q;
  logic [1:0]        fsel_q;
  logic [ADDR_W-1:0] idx_q;
  logic              out_valid_q;
  logic              out_free, last_idx, snap_go, bin_go, room;

  assign out_free = !out_valid_q || out_ready_i;
  assign last_idx = (CNT_W'(idx_q) + CNT_W'(1)) == stat_i.count;
  assign snap_go  = stat_i.mode[fsel_q] && stat_i.step_nz[fsel_q];
  assign bin_go   = stat_i.step_nz[fsel_q];
  assign room     = stat_i.count < CNT_W'(MAX_CLUSTERS);

  always_comb begin
    cmd_o      = '0;
    cmd_o.fsel = fsel_q;
    cmd_o.addr = idx_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SNAP_CHK: begin
        cmd_o.div_start = snap_go;
        cmd_o.div_kind  = DIV_SNAP;
      end
      ST_SNAP_MUL: cmd_o.mul = 1'b1;
      ST_SNAP_ADD: cmd_o.snap_apply = 1'b1;
      ST_CLAMP:    cmd_o.clamp = 1'b1;
      ST_OUT_PASS: begin
        cmd_o.out_load = out_free;
        cmd_o.out_src  = SRC_WORK;
        cmd_o.out_last = 1'b1;
      end
      ST_BIN_CHK: begin
        cmd_o.div_start = bin_go;
        cmd_o.div_kind  = DIV_BIN;
      end
      ST_BIN_DIV:  cmd_o.bin_store = stat_i.div_done;
      ST_SRCH_RD:  cmd_o.rd = 1'b1;
      ST_SRCH_CMP: cmd_o.wr = stat_i.key_match && stat_i.closer;
      ST_INSERT: begin
        cmd_o.addr    = stat_i.count[ADDR_W-1:0];
        cmd_o.wr      = room;
        cmd_o.inc     = room;
        cmd_o.set_ovf = !room;
      end
      ST_FL_RD: cmd_o.rd = 1'b1;
      ST_FL_OUT: begin
        cmd_o.out_load = out_free;
        cmd_o.out_src  = SRC_MEM;
        cmd_o.out_last = last_idx;
        cmd_o.clear    = out_free && last_idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fsel_q      <= F_AZ;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            idx_q  <= '0;
            fsel_q <= F_AZ;
            if (!in_flush_i) state_q <= ST_SNAP_CHK;
            else if (stat_i.count != '0) state_q <= ST_FL_RD;
          end
        end
        ST_SNAP_CHK: begin
          if (snap_go) state_q <= ST_SNAP_DIV;
          else if (fsel_q == F_VEL) state_q <= ST_CLAMP;
          else fsel_q <= fsel_q + 2'd1;
        end
        ST_SNAP_DIV: if (stat_i.div_done) state_q <= ST_SNAP_MUL;
        ST_SNAP_MUL: state_q <= ST_SNAP_ADD;
        ST_SNAP_ADD: begin
          if (fsel_q == F_VEL) state_q <= ST_CLAMP;
          else begin
            fsel_q  <= fsel_q + 2'd1;
            state_q <= ST_SNAP_CHK;
          end
        end
        ST_CLAMP: state_q <= ST_CHECK;
        ST_CHECK: begin
          fsel_q <= F_AZ;
          if (!stat_i.range_ok) state_q <= ST_IDLE;
          else if (!stat_i.mode[MODE_CLUSTER]) state_q <= ST_OUT_PASS;
          else state_q <= ST_BIN_CHK;
        end
        ST_OUT_PASS: if (out_free) state_q <= ST_IDLE;
        ST_BIN_CHK, ST_BIN_DIV: begin
          if (state_q == ST_BIN_CHK && bin_go) state_q <= ST_BIN_DIV;
          else if (state_q == ST_BIN_CHK || stat_i.div_done) begin
            if (fsel_q == F_RNG) begin
              idx_q   <= '0;
              state_q <= (stat_i.count == '0) ? ST_INSERT : ST_SRCH_RD;
            end else begin
              fsel_q  <= fsel_q + 2'd1;
              state_q <= ST_BIN_CHK;
            end
          end
        end
        ST_SRCH_RD: state_q <= ST_SRCH_CMP;
        ST_SRCH_CMP: begin
          if (stat_i.key_match) state_q <= ST_IDLE;
          else if (last_idx) state_q <= ST_INSERT;
          else begin
            idx_q   <= idx_q + ADDR_W'(1);
            state_q <= ST_SRCH_RD;
          end
        end
        ST_INSERT: state_q <= ST_IDLE;
        ST_FL_RD:  state_q <= ST_FL_OUT;
        ST_FL_OUT: begin
          if (out_free) begin
            if (last_idx) state_q <= ST_IDLE;
            else begin
              idx_q   <= idx_q + ADDR_W'(1);
              state_q <= ST_FL_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/core/rdqc_checker.sv =====
`default_nettype none
module rdqc_checker import rdqc_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  cfg_valid_i,
  input wire logic                  cfg_ready_o,
  input wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input wire logic                  s_axis_tvalid_i,
  input wire logic                  s_axis_tready_o,
  input wire logic [TDATA_W-1:0]    s_axis_tdata_i,
  input wire logic                  s_axis_tuser_i,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i,
  input wire logic [TDATA_W-1:0]    m_axis_tdata_o,
  input wire logic                  m_axis_tuser_o,
  input wire logic                  m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output item changed while stalled");

  // A detection always needs work beyond the accepting cycle.
  a_busy_after_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i |=> !s_axis_tready_o)
    else $error("detection accepted without going busy");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[TDATA_W-1:$bits(det_t)] == '0)
    else $error("output pad bits not zero");

endmodule

bind radar_detection_quantize_cluster_core rdqc_checker u_rdqc_checker (.*);
`default_nettype wire

// ===== test/rdqc_checker.sv =====
`timescale 1ns / 100ps
module tb_checker import rdqc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_tvalid_i,
  input  wire logic                  s_tready_i,
  input  wire logic [TDATA_W-1:0]    s_tdata_i,
  input  wire logic                  s_tuser_i,
  input  wire logic                  m_tvalid_i,
  input  wire logic                  m_tready_i,
  input  wire logic [TDATA_W-1:0]    m_tdata_i,
  input  wire logic                  m_tuser_i,
  input  wire logic                  m_tlast_i,
  output int                         errors_o,
  output int                         pending_o
);

  localparam int EXP_DEPTH = 256;

  logic [31:0] az_lim, el_lim, ang_res;
  logic [47:0] rng_lim;
  logic [18:0] vel_lim, vel_res;
  logic [23:0] rng_res;
  logic [4:0]  mode;

  logic [55:0] bin_key [MAX_CLUSTERS];
  det_t        bin_det [MAX_CLUSTERS];
  int          n_bins;
  bit          dropped;

  // Expected results in order, as a ring indexed by running counts.
  det_t        exp_det [EXP_DEPTH];
  bit          exp_last [EXP_DEPTH];
  bit          exp_ovf [EXP_DEPTH];
  int          wr_cnt = 0;
  int          rd_cnt = 0;

  assign pending_o = wr_cnt - rd_cnt;

  task automatic add_expected(det_t d, bit last, bit ovf);
    exp_det[wr_cnt % EXP_DEPTH] = d;
    exp_last[wr_cnt % EXP_DEPTH] = last;
    exp_ovf[wr_cnt % EXP_DEPTH] = ovf;
    wr_cnt++;
  endtask

  function automatic longint snap_to_grid(longint v, longint step, longint origin);
    longint d, q;
    if (step <= 0) return v;
    d = v - origin;
    if (d >= 0) q = (2 * d + step) / (2 * step);
    else q = -((-2 * d + step) / (2 * step));
    return origin + q * step;
  endfunction

  function automatic longint floor_quot(longint d, longint r);
    longint q;
    q = d / r;
    if (d % r != 0 && d < 0) q--;
    return q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  task automatic predict_item(bit flush, det_t di);
    longint az_min, az_max, el_min, el_max, r_min, r_max, vl;
    longint az_st, el_st, r_st, v_st;
    longint az, el, r, v, ab, eb, rb;
    logic [55:0] key;
    det_t nd;
    bit hit;
    az_min = longint'($signed(az_lim[15:0]));
    az_max = longint'($signed(az_lim[31:16]));
    el_min = longint'($signed(el_lim[15:0]));
    el_max = longint'($signed(el_lim[31:16]));
    r_min = longint'(rng_lim[23:0]);
    r_max = longint'(rng_lim[47:24]);
    vl = longint'(vel_lim);
    az_st = longint'(ang_res[15:0]);
    el_st = longint'(ang_res[31:16]);
    r_st = longint'(rng_res);
    v_st = longint'(vel_res);
    if (flush) begin
      for (int i = 0; i < n_bins; i++) begin
        add_expected(bin_det[i], i == n_bins - 1, dropped);
      end
      n_bins = 0;
      dropped = 0;
      return;
    end
    az = longint'($signed(di.az));
    el = longint'($signed(di.el));
    r = longint'(di.rng);
    v = longint'($signed(di.vel));
    if (mode[0]) az = snap_to_grid(az, az_st, az_min);
    if (mode[1]) el = snap_to_grid(el, el_st, el_min);
    if (mode[2]) r = snap_to_grid(r, r_st, r_min);
    if (mode[3]) v = snap_to_grid(v, v_st, 0);
    az = clip(az, az_min, az_max);
    el = clip(el, el_min, el_max);
    r = clip(r, r_min, r_max);
    v = clip(v, -vl, vl);
    // Inverted range limits leave the range outside them: the detection is dropped.
    if (r < r_min || r > r_max) return;
    nd.az = az[15:0];
    nd.el = el[15:0];
    nd.rng = r[23:0];
    nd.vel = v[19:0];
    nd.cs = di.cs;
    if (!mode[MODE_CLUSTER]) begin
      add_expected(nd, 1'b1, 1'b0);
      return;
    end
    ab = az_st > 0 ? floor_quot(az - az_min, az_st) : 0;
    eb = el_st > 0 ? floor_quot(el - el_min, el_st) : 0;
    rb = r_st > 0 ? floor_quot(r - r_min, r_st) : 0;
    key = {rb[23:0], eb[15:0], ab[15:0]};
    hit = 0;
    for (int i = 0; i < n_bins; i++) begin
      if (!hit && bin_key[i] == key) begin
        hit = 1;
        if (r < longint'(bin_det[i].rng)) bin_det[i] = nd;
      end
    end
    if (hit) return;
    if (n_bins < MAX_CLUSTERS) begin
      bin_key[n_bins] = key;
      bin_det[n_bins] = nd;
      n_bins++;
    end else begin
      dropped = 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      az_lim = 32'd1073725440;
      el_lim = 32'd1073725440;
      rng_lim = 48'd281474959933440;
      vel_lim = 19'd524287;
      ang_res = '0;
      rng_res = '0;
      vel_res = '0;
      mode = '0;
      n_bins = 0;
      dropped = 0;
      wr_cnt = 0;
      rd_cnt = 0;
      errors_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          REG_AZ_LIMITS:  az_lim = cfg_data_i[31:0];
          REG_EL_LIMITS:  el_lim = cfg_data_i[31:0];
          REG_RNG_LIMITS: rng_lim = cfg_data_i[47:0];
          REG_VEL_LIMIT:  vel_lim = cfg_data_i[18:0];
          REG_ANG_RES:    ang_res = cfg_data_i[31:0];
          REG_RNG_RES:    rng_res = cfg_data_i[23:0];
          REG_VEL_RES:    vel_res = cfg_data_i[18:0];
          REG_MODE:       mode = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        det_t got;
        int   slot;
        got = m_tdata_i[91:0];
        if (wr_cnt == rd_cnt) begin
          errors_o++;
          if (errors_o <= 10)
            $display("unexpected result item: data %h last %b ovf %b", got, m_tlast_i,
                     m_tuser_i);
        end else begin
          slot = rd_cnt % EXP_DEPTH;
          rd_cnt++;
          if (got !== exp_det[slot] || m_tlast_i !== exp_last[slot] ||
              m_tuser_i !== exp_ovf[slot]) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("mismatch: exp az %h el %h rng %h vel %h cs %h last %b ovf %b",
                       exp_det[slot].az, exp_det[slot].el, exp_det[slot].rng,
                       exp_det[slot].vel, exp_det[slot].cs, exp_last[slot],
                       exp_ovf[slot]);
              $display("          got az %h el %h rng %h vel %h cs %h last %b ovf %b",
                       got.az, got.el, got.rng, got.vel, got.cs, m_tlast_i, m_tuser_i);
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i) predict_item(s_tuser_i, det_t'(s_tdata_i[91:0]));
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import rdqc_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 4'd9;
  localparam logic OP_DET = 1'b0;
  localparam logic OP_FLUSH = 1'b1;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [TDATA_W-1:0] s_data = '0;
  logic s_user = 1'b0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [TDATA_W-1:0] m_data;
  logic m_user, m_last;
  int errors, pending;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_seq = 0;
  int cycles = 0;

  // Centers that detections gather around so that bins collide.
  logic [15:0] az_ctr[4], el_ctr[4];
  logic [23:0] rng_ctr[4];

  always #5 clk = ~clk;

  radar_detection_quantize_cluster_core u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_addr_i(cfg_addr), .cfg_data_i(cfg_data),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last)
  );

  tb_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_addr_i(cfg_addr), .cfg_data_i(cfg_data),
    .s_tvalid_i(s_valid), .s_tready_i(s_ready), .s_tdata_i(s_data), .s_tuser_i(s_user),
    .m_tvalid_i(m_valid), .m_tready_i(m_ready), .m_tdata_i(m_data),
    .m_tuser_i(m_user), .m_tlast_i(m_last),
    .errors_o(errors), .pending_o(pending)
  );

  // Result side: random stalls, plus a long hold-off whenever hold_seq moves.
  always @(posedge clk) begin
    int seen_seq, hold_left;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      if (hold_seq != seen_seq) begin
        seen_seq = hold_seq;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic set_idling(int k);
    case (k % 4)
      0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      1: begin src_idle_pct = 76; snk_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_stall_pct = 76; end
      default: begin src_idle_pct = 35; snk_stall_pct = 35; end
    endcase
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic det_send(logic op, logic [15:0] az, logic [15:0] el, logic [23:0] rng,
                          logic [19:0] vel, logic [15:0] cs);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user <= op;
    s_data <= {4'h0, cs, vel, rng, el, az};
    do @(posedge clk); while (!s_ready);
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_det(bit gathered);
    logic [15:0] az, el;
    logic [23:0] rng;
    logic [19:0] vel;
    az = 16'($urandom);
    el = 16'($urandom);
    rng = 24'($urandom);
    vel = 20'($urandom);
    if (gathered) begin
      az = az_ctr[$urandom_range(3)] + 16'($urandom_range(24)) - 16'd12;
      el = el_ctr[$urandom_range(3)] + 16'($urandom_range(24)) - 16'd12;
      rng = rng_ctr[$urandom_range(3)] + 24'($urandom_range(64));
      vel = 20'($signed(20'($urandom_range(4000))) - 20'sd2000);
    end
    det_send(OP_DET, az, el, rng, vel, 16'($urandom));
  endtask

  // kind 0: every register at its top value, kind 1: all zero but the mode, else random.
  task automatic pick_config(int kind, bit pass_only);
    logic signed [15:0] a0, a1, e0, e1;
    logic [23:0] r0, r1;
    logic [4:0] md;
    r0 = '0;
    if (kind == 0) begin
      cfg_write(REG_AZ_LIMITS, 48'hFFFF_FFFF);
      cfg_write(REG_EL_LIMITS, 48'hFFFF_FFFF);
      cfg_write(REG_RNG_LIMITS, 48'hFFFF_FFFF_FFFF);
      cfg_write(REG_VEL_LIMIT, 48'h7FFFF);
      cfg_write(REG_ANG_RES, 48'hFFFF_FFFF);
      cfg_write(REG_RNG_RES, 48'hFF_FFFF);
      cfg_write(REG_VEL_RES, 48'h7FFFF);
      md = 5'h1F;
    end else if (kind == 1) begin
      cfg_write(REG_AZ_LIMITS, '0);
      cfg_write(REG_EL_LIMITS, '0);
      cfg_write(REG_RNG_LIMITS, '0);
      cfg_write(REG_VEL_LIMIT, '0);
      cfg_write(REG_ANG_RES, '0);
      cfg_write(REG_RNG_RES, '0);
      cfg_write(REG_VEL_RES, '0);
      md = 5'h1F;
    end else begin
      a0 = -16'sd20000 + 16'($urandom_range(8000));
      a1 = 16'sd12000 + 16'($urandom_range(8000));
      e0 = -16'sd20000 + 16'($urandom_range(8000));
      e1 = 16'sd12000 + 16'($urandom_range(8000));
      r0 = 24'($urandom_range(5000));
      r1 = 24'h800000 + 24'($urandom_range(24'h7FFFFF));
      if ($urandom_range(7) == 0) begin
        a0 = a1;
        a1 = -16'sd3000;
      end
      if ($urandom_range(7) == 0) begin
        r1 = r0 / 2;
      end
      cfg_write(REG_AZ_LIMITS, {16'h0, a1, a0});
      cfg_write(REG_EL_LIMITS, {16'h0, e1, e0});
      cfg_write(REG_RNG_LIMITS, {r1, r0});
      cfg_write(REG_VEL_LIMIT, 48'($urandom_range(1000, 524287)));
      cfg_write(REG_ANG_RES, {16'h0, 16'($urandom_range(1500)), 16'($urandom_range(1500))});
      cfg_write(REG_RNG_RES, 48'($urandom_range(20000)));
      cfg_write(REG_VEL_RES, 48'($urandom_range(600)));
      md = 5'($urandom);
    end
    for (int i = 0; i < 4; i++) begin
      az_ctr[i] = 16'($urandom);
      el_ctr[i] = 16'($urandom);
      rng_ctr[i] = r0 + 24'($urandom_range(100000));
    end
    if (pass_only) md[MODE_CLUSTER] = 1'b0;
    cfg_write(REG_MODE, {43'h0, md});
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // Default setup, pass-through: field extremes.
    det_send(OP_DET, 16'h8000, 16'h7FFF, 24'h000000, 20'h80000, 16'h0000);
    det_send(OP_DET, 16'h7FFF, 16'h8000, 24'hFFFFFF, 20'h7FFFF, 16'hFFFF);
    det_send(OP_FLUSH, 16'h0, 16'h0, 24'h0, 20'h0, 16'h0);
    wait_drained();

    // Snap everything; ties round away from zero on both sides of the minimum.
    cfg_write(REG_AZ_LIMITS, {16'h0, 16'd1000, 16'hFC18});
    cfg_write(REG_ANG_RES, {16'h0, 16'd100, 16'd8});
    cfg_write(REG_RNG_RES, 48'd10);
    cfg_write(REG_VEL_RES, 48'd4);
    cfg_write(REG_MODE, 48'h0F);
    cfg_write(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
    det_send(OP_DET, 16'hFC1C, 16'hC032, 24'd5, 20'hFFFFE, 16'h1234);
    det_send(OP_DET, 16'hFC14, 16'h0000, 24'd15, 20'd2, 16'h4321);
    det_send(OP_DET, 16'h7000, 16'hC031, 24'd14, 20'd6, 16'h0001);
    wait_drained();

    // Inverted range limits drop the detection; inverted azimuth gives its maximum.
    cfg_write(REG_RNG_LIMITS, {24'd50, 24'd100});
    det_send(OP_DET, 16'h0, 16'h0, 24'd70, 20'd0, 16'h5555);
    wait_drained();
    cfg_write(REG_RNG_LIMITS, {24'hFFFFFF, 24'd0});
    cfg_write(REG_AZ_LIMITS, {16'h0, 16'hFE0C, 16'd500});
    cfg_write(REG_VEL_LIMIT, 48'd100);
    det_send(OP_DET, 16'h0123, 16'h0, 24'd70, 20'hFFF00, 16'h5555);
    wait_drained();

    // Clustering: same bin and equal range, a closer range in its own bin, negative azimuth bins, then flushes.
    cfg_write(REG_MODE, 48'h10);
    det_send(OP_DET, 16'h0010, 16'h0, 24'd100, 20'd1, 16'h0A0A);
    det_send(OP_DET, 16'h0020, 16'h0, 24'd100, 20'd2, 16'h0B0B);
    det_send(OP_DET, 16'h0030, 16'h0, 24'd95, 20'd3, 16'h0C0C);
    det_send(OP_DET, 16'h0040, 16'h0, 24'd500, 20'd4, 16'h0D0D);
    det_send(OP_DET, 16'h0050, 16'h1000, 24'd20, 20'd5, 16'h0E0E);
    det_send(OP_FLUSH, 16'h0, 16'h0, 24'h0, 20'h0, 16'h0);
    det_send(OP_FLUSH, 16'h0, 16'h0, 24'h0, 20'h0, 16'h0);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      pick_config(p, p == 3);
      set_idling(p);
      if (p == 3) hold_seq++;
      for (int i = 0; i < 13; i++) begin
        if ($urandom_range(9) == 0) det_send(OP_FLUSH, 16'($urandom), 16'($urandom),
                                             24'($urandom), 20'($urandom), 16'($urandom));
        else send_random_det($urandom_range(9) < 7);
      end
      det_send(OP_FLUSH, 16'h0, 16'h0, 24'h0, 20'h0, 16'h0);
      wait_drained();
    end

    // Table overflow: more distinct range bins than the table holds.
    cfg_write(REG_AZ_LIMITS, {16'h0, 16'h7FFF, 16'h8000});
    cfg_write(REG_RNG_LIMITS, {24'hFFFFFF, 24'd0});
    cfg_write(REG_ANG_RES, '0);
    cfg_write(REG_RNG_RES, 48'd1);
    cfg_write(REG_MODE, 48'h10);
    set_idling(3);
    for (int i = 0; i < 66; i++)
      det_send(OP_DET, 16'($urandom), 16'($urandom), 24'(i * 3 + 1), 20'($urandom),
               16'($urandom));
    det_send(OP_DET, 16'h0, 16'h0, 24'd1, 20'd0, 16'h0);
    det_send(OP_FLUSH, 16'h0, 16'h0, 24'h0, 20'h0, 16'h0);
    wait_drained();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
